// File: rtl/core/dsi_pkg.sv
// Package for the decimal string to integer converter.
// Holds the parse state, result and character constants shared by dsi_step and the top level.
// No dependencies.
package dsi_pkg;

    localparam int CHAR_W      = 8;
    localparam int MAG_W       = 31;
    localparam int VALUE_W     = 32;
    localparam int DIGIT_CNT_W = 4;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_DIGITS = 2'd1,
        PH_STOP   = 2'd2
    } dsi_phase_t;

    typedef struct packed {
        dsi_phase_t             phase;
        logic                   negative;
        logic [MAG_W-1:0]       magnitude;
        logic [DIGIT_CNT_W-1:0] digit_count;
        logic                   overflowed;
    } dsi_state_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      overflow;
    } dsi_result_t;

    localparam dsi_state_t STATE_RESET = '{
        phase:       PH_FIRST,
        negative:    1'b0,
        magnitude:   '0,
        digit_count: '0,
        overflowed:  1'b0
    };

endpackage

// File: rtl/core/decimal_string_to_int_top.sv
// Timing: a character request is first accepted into the input register and is parsed at the
// next edge at which the result register is free; when it carries tlast, its result is loaded
// into the result register at that same edge, and m_tvalid is driven from that register.
// Throughput: one character per cycle, set by the single multiply-by-ten-add and compare
// step; while a result waits with m_tready low, the input stage stalls.
// Reset (aresetn low at a rising edge) empties both stages and returns the parser to the
// state that expects the first character of a new string.
module decimal_string_to_int_top
    import dsi_pkg::*;
#(
    parameter int MAX_DIGITS = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Slave side: one character request per transfer.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] ch
    input  logic                      s_tlast,   // last character of the string
    // Master side: one result request per string.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic signed [31:0]        m_tdata,   // [31:0] value
    output logic [0:0]                m_tuser    // [0] overflow
);

    // Input register: holds one accepted character until the parser consumes it.
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_ch_reg;
    logic              in_last_reg;

    // Parse state carried from character to character within a string.
    dsi_state_t  state_reg;
    dsi_state_t  state_next;
    dsi_result_t result;

    // Result register on the master side.
    logic                      m_valid_reg;
    logic signed [VALUE_W-1:0] m_value_reg;
    logic                      m_ovf_reg;

    logic advance;

    // The held character is consumed whenever the result register can take
    // whatever it may produce: it is empty or being drained this cycle.
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    dsi_step #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_step (
        .state_cur  (state_reg),
        .ch         (in_ch_reg),
        .last       (in_last_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_ch_reg   <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Only the final character of a string loads a result; the register is
    // free here because advance already required that.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && in_last_reg) begin
            m_value_reg <= result.value;
            m_ovf_reg   <= result.overflow;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_value_reg;
    assign m_tuser[0] = m_ovf_reg;

    // An overflowed string always reports zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_ovf_reg |-> m_value_reg == '0)
        else $error("overflow result with nonzero value");

    // The digit count never passes its limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.digit_count <= DIGIT_CNT_W'(MAX_DIGITS))
        else $error("digit count beyond limit");

    // Overflow always stops accumulation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.overflowed |-> state_reg.phase == PH_STOP)
        else $error("overflow without stop");

    // Consuming the last character leaves the parser in its reset state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> state_reg == STATE_RESET)
        else $error("parser not cleared after end of string");

    // A held character that cannot advance stays held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_ch_reg))
        else $error("stalled character lost");

endmodule

// File: rtl/core/dsi_step.sv
// Combinational step of the decimal string parser: one character against the current state.
// Produces the next parse state and the result for a string that ends here. Uses dsi_pkg.
module dsi_step
    import dsi_pkg::*;
#(
    parameter int MAX_DIGITS = 10
) (
    input  dsi_state_t        state_cur,
    input  logic [CHAR_W-1:0] ch,
    input  logic              last,
    output dsi_state_t        state_next,
    output dsi_result_t       result
);

    localparam logic [MAG_W+3:0] MAG_LIMIT = {4'b0000, {MAG_W{1'b1}}};

    dsi_state_t       upd;
    logic             take;
    logic             is_digit;
    logic             count_full;
    logic [3:0]       digit_val;
    logic [MAG_W+3:0] scaled;
    logic             too_big;

    assign is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
    // For the codes '0' through '9' the low nibble is the digit itself.
    assign digit_val  = ch[3:0];
    assign count_full = state_cur.digit_count >= DIGIT_CNT_W'(MAX_DIGITS);

    // Ten times the magnitude plus the new digit, kept wide enough to never wrap.
    assign scaled  = {1'b0, state_cur.magnitude, 3'b000}
                   + {3'b000, state_cur.magnitude, 1'b0}
                   + {{(MAG_W){1'b0}}, digit_val};
    assign too_big = scaled > MAG_LIMIT;

    always_comb begin
        upd  = state_cur;
        take = 1'b0;
        case (state_cur.phase)
            PH_FIRST: begin
                upd.phase = PH_DIGITS;
                if (ch == CH_MINUS) begin
                    upd.negative = 1'b1;
                end else if (ch != CH_PLUS) begin
                    take = 1'b1;
                end
            end
            PH_DIGITS: begin
                take = 1'b1;
            end
            default: begin
                take = 1'b0;
            end
        endcase

        if (take) begin
            if (!is_digit || count_full) begin
                upd.phase = PH_STOP;
            end else if (too_big) begin
                upd.overflowed = 1'b1;
                upd.phase      = PH_STOP;
            end else begin
                upd.magnitude   = scaled[MAG_W-1:0];
                upd.digit_count = state_cur.digit_count + 1'b1;
            end
        end
    end

    always_comb begin
        result.overflow = upd.overflowed;
        if (upd.overflowed) begin
            result.value = '0;
        end else if (upd.negative) begin
            result.value = -$signed({1'b0, upd.magnitude});
        end else begin
            result.value = $signed({1'b0, upd.magnitude});
        end
    end

    // A finished string leaves the parser ready for the next one.
    assign state_next = last ? STATE_RESET : upd;

endmodule
